// ===== design/ubt_pkg.sv =====
// shared types, codes and the microcode program of the bag table
package ubt_pkg;

  // operation codes carried by the mode field
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_COUNT  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // microprogram step addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [STEP_W-1:0] ST_ADD      = 3'd1;
  localparam logic [STEP_W-1:0] ST_REM_SCAN = 3'd2;
  localparam logic [STEP_W-1:0] ST_REM_LAST = 3'd3;
  localparam logic [STEP_W-1:0] ST_REM_WR   = 3'd4;
  localparam logic [STEP_W-1:0] ST_CNT_SCAN = 3'd5;
  localparam logic [STEP_W-1:0] ST_CLR      = 3'd6;
  localparam logic [STEP_W-1:0] ST_DONE     = 3'd7;

  // sequencing kinds
  localparam logic [1:0] J_ACCEPT = 2'd0;  // hold until a request, then dispatch on mode
  localparam logic [1:0] J_GOTO   = 2'd1;  // unconditional jump to target
  localparam logic [1:0] J_SCAN   = 2'd2;  // loop; target on hit if stop_hit is set, done step at end
  localparam logic [1:0] J_EMIT   = 2'd3;  // hold until the result slot frees, then target

  typedef struct packed {
    logic [1:0]        jmp;
    logic [STEP_W-1:0] target;
    logic              scan;      // step the scan pointer and compare
    logic              stop_hit;  // leave the scan on the first match
    logic              acc;       // count matches
    logic              add;       // append the held value
    logic              clr;       // empty the store
    logic              rd_last;   // read the last stored entry
    logic              wr_swap;   // move the last entry into the hit slot
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      ST_IDLE:     w = '{jmp: J_ACCEPT, target: ST_IDLE, default: '0};
      ST_ADD:      w = '{jmp: J_GOTO, target: ST_DONE, add: 1'b1, default: '0};
      ST_REM_SCAN: w = '{jmp: J_SCAN, target: ST_REM_LAST, scan: 1'b1, stop_hit: 1'b1,
                         default: '0};
      ST_REM_LAST: w = '{jmp: J_GOTO, target: ST_REM_WR, rd_last: 1'b1, default: '0};
      ST_REM_WR:   w = '{jmp: J_GOTO, target: ST_DONE, wr_swap: 1'b1, default: '0};
      ST_CNT_SCAN: w = '{jmp: J_SCAN, target: ST_DONE, scan: 1'b1, acc: 1'b1, default: '0};
      ST_CLR:      w = '{jmp: J_GOTO, target: ST_DONE, clr: 1'b1, default: '0};
      ST_DONE:     w = '{jmp: J_EMIT, target: ST_IDLE, default: '0};
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] step_of_mode(input logic [1:0] m);
    logic [STEP_W-1:0] s;
    s = ST_IDLE;
    unique case (m)
      MODE_ADD:    s = ST_ADD;
      MODE_REMOVE: s = ST_REM_SCAN;
      MODE_COUNT:  s = ST_CNT_SCAN;
      MODE_CLEAR:  s = ST_CLR;
    endcase
    return s;
  endfunction

endpackage

// ===== design/ubt_ram.sv =====
// generic single write port ram with a registered read port
module ubt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/unordered_bag_table.sv =====
// unordered bag table: fixed-capacity multiset driven by a microcoded sequencer
//
// request channel (req_valid / req_stall, fields mode and item_value) carries one
// operation per transaction: add, remove, count occurrences or clear. the
// response channel (rsp_valid / rsp_stall) returns exactly one transaction per
// request with ok, frequency, occupancy and the empty and full flags.
// the block works on one request at a time; req_stall is low only while the
// sequencer sits in its idle step.
// add and clear pass through their own step and then the done step; count scans
// all stored entries; remove scans until the first match, then reads the last
// entry and writes it into the hit slot, or goes to the done step when nothing
// matches. the scan reads one entry per cycle through the single read port of
// the entry ram and one comparator.
// the response sits in an output register; a new request is taken while the
// previous response is still stalled, and the sequencer only waits in its
// done step if a second response is ready before the first one is taken.
// reset empties the store (count to zero, no clearing pass) and drops any
// pending response; the entry ram itself is not cleared.
module unordered_bag_table import ubt_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 16,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            mode,
  input  logic [ITEM_WIDTH-1:0] item_value,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  ok,
  output logic [CW-1:0]         frequency,
  output logic [CW-1:0]         occupancy,
  output logic                  is_empty,
  output logic                  is_full
);

  // sequencer
  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ucode_t            u;

  // datapath registers
  logic [CW-1:0]         count;     // stored entries
  logic [CW-1:0]         idx;       // scan read pointer
  logic                  pend;      // a scan read was issued last cycle
  logic [AW-1:0]         pend_idx;  // address of that read
  logic [AW-1:0]         hit_idx;   // slot of the first match on remove
  logic [CW-1:0]         freq;
  logic                  op_ok;
  logic [ITEM_WIDTH-1:0] value;

  // ram ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ITEM_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ITEM_WIDTH-1:0] rdata;

  logic          accept;
  logic          issue;
  logic          hit;
  logic          add_ok;
  logic          out_free;
  logic          emit;
  logic [CW-1:0] last_idx;

  always_comb begin
    u         = ucode_rom(pc);
    req_stall = (pc != ST_IDLE);
    accept    = req_valid && !req_stall;
    issue     = u.scan && (idx < count);
    // compare the entry read on the previous cycle
    hit       = pend && (rdata == value);
    add_ok    = (count < CW'(CAPACITY));
    last_idx  = count - 1'b1;
    out_free  = !rsp_valid || !rsp_stall;
    emit      = (u.jmp == J_EMIT) && out_free;

    // add appends at the count, remove moves the last entry into the hit slot
    ram_we    = (u.add && add_ok) || u.wr_swap;
    ram_waddr = u.add ? count[AW-1:0] : hit_idx;
    ram_wdata = u.add ? value : rdata;
    ram_raddr = u.rd_last ? last_idx[AW-1:0] : idx[AW-1:0];
  end

  // next step
  always_comb begin
    pc_next = pc;
    unique case (u.jmp)
      J_ACCEPT: begin
        if (accept) begin
          pc_next = step_of_mode(mode);
        end
      end
      J_GOTO: begin
        pc_next = u.target;
      end
      J_SCAN: begin
        if (u.stop_hit && hit) begin
          pc_next = u.target;
        end else if (!issue) begin
          // last pending compare lands this cycle
          pc_next = ST_DONE;
        end
      end
      J_EMIT: begin
        if (out_free) begin
          pc_next = u.target;
        end
      end
    endcase
  end

  ubt_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pc <= pc_next;

      if (accept) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (u.scan) begin
        pend <= issue;
        if (issue) begin
          idx <= idx + 1'b1;
        end
      end

      if (u.add && add_ok) begin
        count <= count + 1'b1;
      end else if (u.clr) begin
        count <= '0;
      end else if (u.wr_swap) begin
        count <= last_idx;
      end

      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      value <= item_value;
      freq  <= '0;
      op_ok <= 1'b0;
    end else begin
      if (u.add) begin
        op_ok <= add_ok;
      end
      if (u.clr || u.wr_swap) begin
        op_ok <= 1'b1;
      end
      if (u.acc && hit) begin
        freq <= freq + 1'b1;
      end
    end

    if (u.scan) begin
      pend_idx <= idx[AW-1:0];
    end
    if (u.stop_hit && hit) begin
      hit_idx <= pend_idx;
    end

    if (emit) begin
      // a nonzero frequency is the answer to contains
      ok        <= op_ok || (freq != '0);
      frequency <= freq;
      occupancy <= count;
      is_empty  <= (count == '0);
      is_full   <= (count == CW'(CAPACITY));
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (pc != ST_IDLE))
    else $error("sequencer idle right after taking a request");

  a_swap_nonempty: assert property (@(posedge clk) disable iff (rst)
    u.wr_swap |-> (count != '0))
    else $error("remove write with an empty store");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(pc) == ST_DONE))
    else $error("response raised outside the done step");

endmodule
